@@ sv/chc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the CORDIC arctangent table for the compass heading block.
package chc_pkg;

  localparam int CORDIC_STEPS_DEF   = 16;
  localparam int GAIN_FRAC_BITS_DEF = 24;
  localparam int ATAN_LEN           = 24;

  localparam int SAMPLE_W = 13;
  localparam int DIFF_W   = 14;
  localparam int GAIN_W   = 25;
  localparam int PROD_W   = 40;
  localparam int VEC_W    = 42;
  localparam int MM_W     = 15;
  localparam int DIV_W    = 15;
  localparam int HEAD_W   = 16;
  localparam int CFG_W    = 25;

  localparam logic [GAIN_W-1:0] GAIN_MASK = '1;

  localparam logic signed [SAMPLE_W-1:0] OFFSET_Y_RST = 13'sd10;
  localparam logic signed [SAMPLE_W-1:0] OFFSET_Z_RST = -13'sd32;
  localparam logic [GAIN_W-1:0]          GAIN_Y_RST   = 25'd154350;
  localparam logic [GAIN_W-1:0]          GAIN_Z_RST   = 25'd142606;
  localparam logic signed [MM_W-1:0]     MIN_RST      = 15'sd9999;
  localparam logic signed [MM_W-1:0]     MAX_RST      = -15'sd9999;

  localparam logic RESULT_HEADING = 1'b0;
  localparam logic RESULT_FINISH  = 1'b1;

  typedef enum logic [1:0] {
    CMD_HEADING    = 2'd0,
    CMD_CAL_START  = 2'd1,
    CMD_CAL_SAMPLE = 2'd2,
    CMD_CAL_FINISH = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_OFFSET_Y = 2'd0,
    REG_OFFSET_Z = 2'd1,
    REG_GAIN_Y   = 2'd2,
    REG_GAIN_Z   = 2'd3
  } reg_e;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  // atan(2^-i) in units of 2^32 per turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:    v = 32'h2000_0000;
      5'd1:    v = 32'h12E4_051E;
      5'd2:    v = 32'h09FB_385B;
      5'd3:    v = 32'h0511_11D4;
      5'd4:    v = 32'h028B_0D43;
      5'd5:    v = 32'h0145_D7E1;
      5'd6:    v = 32'h00A2_F61E;
      5'd7:    v = 32'h0051_7C55;
      5'd8:    v = 32'h0028_BE53;
      5'd9:    v = 32'h0014_5F2F;
      5'd10:   v = 32'h000A_2F98;
      5'd11:   v = 32'h0005_17CC;
      5'd12:   v = 32'h0002_8BE6;
      5'd13:   v = 32'h0001_45F3;
      5'd14:   v = 32'h0000_A2FA;
      5'd15:   v = 32'h0000_517D;
      5'd16:   v = 32'h0000_28BE;
      5'd17:   v = 32'h0000_145F;
      5'd18:   v = 32'h0000_0A30;
      5'd19:   v = 32'h0000_0518;
      5'd20:   v = 32'h0000_028C;
      5'd21:   v = 32'h0000_0146;
      5'd22:   v = 32'h0000_00A3;
      5'd23:   v = 32'h0000_0051;
      default: v = 32'h0000_0000;
    endcase
    return v;
  endfunction

endpackage

@@ sv/chc_if.sv @@
`timescale 1ns / 1ps
// Handshake interfaces for the command, result and register write channels.
interface chc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           command;
  logic signed [chc_pkg::SAMPLE_W-1:0]  sample_y;
  logic signed [chc_pkg::SAMPLE_W-1:0]  sample_z;
  logic                                 sample_ok;

  modport source (output valid, command, sample_y, sample_z, sample_ok, input ready);
  modport sink   (input valid, command, sample_y, sample_z, sample_ok, output ready);
endinterface

interface chc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic [chc_pkg::HEAD_W-1:0]           heading;
  logic signed [chc_pkg::SAMPLE_W-1:0]  new_offset_y;
  logic signed [chc_pkg::SAMPLE_W-1:0]  new_offset_z;
  logic [chc_pkg::GAIN_W-1:0]           new_gain_y;
  logic [chc_pkg::GAIN_W-1:0]           new_gain_z;
  logic                                 calib_fault;
  logic                                 result_kind;

  modport source (output valid, heading, new_offset_y, new_offset_z, new_gain_y, new_gain_z,
                  calib_fault, result_kind, input ready);
  modport sink   (input valid, heading, new_offset_y, new_offset_z, new_gain_y, new_gain_z,
                  calib_fault, result_kind, output ready);
endinterface

interface chc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 index;
  logic [chc_pkg::CFG_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/chc_cordic.sv @@
`timescale 1ns / 1ps
// Iterative vectoring CORDIC: one micro-rotation per cycle, angle in 2^32 units per turn.
module chc_cordic #(
  parameter int CORDIC_STEPS = chc_pkg::CORDIC_STEPS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [chc_pkg::VEC_W-1:0]   y_i,
  input  logic signed [chc_pkg::VEC_W-1:0]   x_i,
  output chc_pkg::unit_status_t              status_o,
  output logic [chc_pkg::HEAD_W-1:0]         angle_o
);

  localparam int NSTEPS = (CORDIC_STEPS < chc_pkg::ATAN_LEN) ? CORDIC_STEPS : chc_pkg::ATAN_LEN;
  localparam int STEP_W = $clog2(NSTEPS);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NSTEPS - 1);

  logic signed [chc_pkg::VEC_W-1:0] x_q, y_q, dx, dy;
  logic [31:0]                      ang_q, rnd, step_ang;
  logic [STEP_W-1:0]                step_q;
  logic                             busy_q, done_q, zero_q;

  always_comb begin
    dx       = y_q >>> step_q;
    dy       = x_q >>> step_q;
    step_ang = chc_pkg::atan_turn(5'(step_q));
    rnd      = ang_q + 32'h0000_8000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      x_q    <= '0;
      y_q    <= '0;
      ang_q  <= '0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        zero_q <= (y_i == '0) && (x_i == '0);
        step_q <= '0;
        busy_q <= 1'b1;
        // Fold the left half plane onto the right one with a half-turn offset.
        if (x_i[chc_pkg::VEC_W-1]) begin
          x_q   <= -x_i;
          y_q   <= -y_i;
          ang_q <= 32'h8000_0000;
        end else begin
          x_q   <= x_i;
          y_q   <= y_i;
          ang_q <= 32'h0000_0000;
        end
      end else if (busy_q) begin
        if (y_q > 0) begin
          x_q   <= x_q + dx;
          y_q   <= y_q - dy;
          ang_q <= ang_q + step_ang;
        end else begin
          x_q   <= x_q - dx;
          y_q   <= y_q + dy;
          ang_q <= ang_q - step_ang;
        end
        step_q <= step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign angle_o       = zero_q ? '0 : rnd[31:16];

endmodule

@@ sv/chc_div.sv @@
`timescale 1ns / 1ps
// Restoring unsigned divider that retires one quotient bit per cycle.
module chc_div #(
  parameter int DW = chc_pkg::GAIN_FRAC_BITS_DEF + 1
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [DW-1:0]                   dividend_i,
  input  logic [chc_pkg::DIV_W-1:0]       divisor_i,
  output chc_pkg::unit_status_t           status_o,
  output logic [DW-1:0]                   quotient_o
);

  localparam int CNT_W = $clog2(DW + 1);
  localparam int DIV_W = chc_pkg::DIV_W;

  logic [DIV_W-1:0] rem_q, dvs_q, rem_d;
  logic [DW-1:0]    q_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q, fits;
  logic [DIV_W:0]   trial, diff;

  always_comb begin
    trial = {rem_q, q_q[DW-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = trial >= {1'b0, dvs_q};
    rem_d = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
      rem_q  <= '0;
      dvs_q  <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        rem_q <= '0;
        dvs_q <= divisor_i;
        q_q   <= dividend_i;
        cnt_q <= CNT_W'(DW);
      end else if (cnt_q != '0) begin
        rem_q <= rem_d;
        q_q   <= {q_q[DW-2:0], fits};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  assign status_o.busy = (cnt_q != '0);
  assign status_o.done = done_q;
  assign quotient_o    = q_q;

endmodule

@@ sv/compass_heading_calibration_top.sv @@
`timescale 1ns / 1ps
// Heading: the accepted beat's y and z products are registered in turn, then the CORDIC rotates them.
// Finish: each axis in turn sets its offset and span, then waits for its gain from the divider.
// A flat span skips its division. Start and sample commands complete in the accepting cycle.
// One command is in work at a time; the input is ready only while the sequencer is idle.
// The result register lets a new beat enter while the previous result waits.
// Reset (asynchronous, active low) loads the register defaults and clears min/max tracking.
module compass_heading_calibration_top #(
  parameter int CORDIC_STEPS   = chc_pkg::CORDIC_STEPS_DEF,
  parameter int GAIN_FRAC_BITS = chc_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  chc_in_if.sink        in_i,
  chc_out_if.source     out_o,
  chc_cfg_if.sink       cfg_i
);

  localparam int DW     = GAIN_FRAC_BITS + 1;
  localparam int GAIN_W = chc_pkg::GAIN_W;
  localparam int MM_W   = chc_pkg::MM_W;
  localparam int VEC_W  = chc_pkg::VEC_W;
  localparam int PROD_W = chc_pkg::PROD_W;
  localparam int SW     = chc_pkg::SAMPLE_W;
  localparam logic [DW-1:0] DIV_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};
  localparam logic [GAIN_W-1:0] GAIN_SAT = (GAIN_FRAC_BITS >= GAIN_W) ?
                                           chc_pkg::GAIN_MASK :
                                           GAIN_W'(64'd1 << GAIN_FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_Y, S_MUL_Z, S_ROT, S_ROT_WAIT, S_FIN_SET, S_FIN_WAIT, S_EMIT
  } state_e;

  state_e state_q;

  // Registers
  logic signed [SW-1:0]   offset_y_q, offset_z_q;
  logic [GAIN_W-1:0]      gain_y_q, gain_z_q;
  logic signed [MM_W-1:0] min_y_q, max_y_q, min_z_q, max_z_q;

  // Work registers of the command in progress
  logic signed [SW-1:0]     sy_q, sz_q;
  logic signed [PROD_W-1:0] yv_q, zv_q;
  logic                     axis_q;
  logic [chc_pkg::HEAD_W-1:0] w_heading_q;
  logic signed [SW-1:0]     w_off_y_q, w_off_z_q;
  logic [GAIN_W-1:0]        w_gain_y_q, w_gain_z_q;
  logic                     w_fault_q, w_kind_q;

  // Result register
  logic                       out_valid_q;
  logic [chc_pkg::HEAD_W-1:0] out_heading_q;
  logic signed [SW-1:0]       out_off_y_q, out_off_z_q;
  logic [GAIN_W-1:0]          out_gain_y_q, out_gain_z_q;
  logic                       out_fault_q, out_kind_q;

  logic in_acc;
  chc_pkg::cmd_e in_cmd;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign in_cmd     = chc_pkg::cmd_e'(in_i.command);
  assign cfg_i.ready = 1'b1;

  // Shared multiplier: offset-corrected sample times unsigned gain.
  logic signed [chc_pkg::DIFF_W-1:0] mul_a;
  logic signed [GAIN_W:0]            mul_b;
  logic signed [PROD_W-1:0]          mul_p;

  always_comb begin
    if (state_q == S_MUL_Z) begin
      mul_a = {sz_q[SW-1], sz_q} - {offset_z_q[SW-1], offset_z_q};
      mul_b = $signed({1'b0, gain_z_q});
    end else begin
      mul_a = {sy_q[SW-1], sy_q} - {offset_y_q[SW-1], offset_y_q};
      mul_b = $signed({1'b0, gain_y_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  // CORDIC
  logic                   cordic_start;
  chc_pkg::unit_status_t  cordic_st;
  logic [chc_pkg::HEAD_W-1:0] cordic_angle;
  logic signed [VEC_W-1:0] cordic_y, cordic_x;

  assign cordic_start = (state_q == S_ROT);
  assign cordic_y     = VEC_W'(yv_q);
  assign cordic_x     = -(VEC_W'(zv_q));

  chc_cordic #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cordic_start),
    .y_i      (cordic_y),
    .x_i      (cordic_x),
    .status_o (cordic_st),
    .angle_o  (cordic_angle)
  );

  // Offset and span of the axis being finished.
  logic signed [MM_W-1:0] fin_mn, fin_mx;
  logic signed [MM_W:0]   fin_sum, fin_half, fin_span;
  logic                   span_bad, div_start;
  logic [DW-1:0]          div_dividend, div_q;
  logic [31:0]            div_q32;
  logic [GAIN_W-1:0]      div_gain;
  chc_pkg::unit_status_t  div_st;

  always_comb begin
    fin_mn   = axis_q ? min_z_q : min_y_q;
    fin_mx   = axis_q ? max_z_q : max_y_q;
    fin_sum  = {fin_mn[MM_W-1], fin_mn} + {fin_mx[MM_W-1], fin_mx};
    // Halve with truncation toward zero.
    fin_half = (fin_sum + $signed({{MM_W{1'b0}}, fin_sum[MM_W]})) >>> 1;
    fin_span = {fin_mx[MM_W-1], fin_mx} - fin_half;
    span_bad = fin_span[MM_W] || (fin_span == '0);
    div_dividend = DIV_ONE + DW'(fin_span[MM_W-1:1]);
    div_start    = (state_q == S_FIN_SET) && !span_bad;
    div_q32      = {{(32 - DW){1'b0}}, div_q};
    div_gain     = (div_q32 > 32'(chc_pkg::GAIN_MASK)) ? chc_pkg::GAIN_MASK
                                                       : div_q32[GAIN_W-1:0];
  end

  chc_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (fin_span[chc_pkg::DIV_W-1:0]),
    .status_o   (div_st),
    .quotient_o (div_q)
  );

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_y_q <= chc_pkg::OFFSET_Y_RST;
      offset_z_q <= chc_pkg::OFFSET_Z_RST;
      gain_y_q   <= chc_pkg::GAIN_Y_RST;
      gain_z_q   <= chc_pkg::GAIN_Z_RST;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (chc_pkg::reg_e'(cfg_i.index))
        chc_pkg::REG_OFFSET_Y: offset_y_q <= cfg_i.data[SW-1:0];
        chc_pkg::REG_OFFSET_Z: offset_z_q <= cfg_i.data[SW-1:0];
        chc_pkg::REG_GAIN_Y:   gain_y_q   <= cfg_i.data[GAIN_W-1:0];
        chc_pkg::REG_GAIN_Z:   gain_z_q   <= cfg_i.data[GAIN_W-1:0];
      endcase
    end
  end

  // Min/max tracking.
  logic signed [MM_W-1:0] smp_y, smp_z;
  assign smp_y = {{(MM_W - SW){in_i.sample_y[SW-1]}}, in_i.sample_y};
  assign smp_z = {{(MM_W - SW){in_i.sample_z[SW-1]}}, in_i.sample_z};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_y_q <= chc_pkg::MIN_RST;
      min_z_q <= chc_pkg::MIN_RST;
      max_y_q <= chc_pkg::MAX_RST;
      max_z_q <= chc_pkg::MAX_RST;
    end else if (in_acc && in_cmd == chc_pkg::CMD_CAL_START) begin
      min_y_q <= chc_pkg::MIN_RST;
      min_z_q <= chc_pkg::MIN_RST;
      max_y_q <= chc_pkg::MAX_RST;
      max_z_q <= chc_pkg::MAX_RST;
    end else if (in_acc && in_cmd == chc_pkg::CMD_CAL_SAMPLE && in_i.sample_ok) begin
      if (smp_y < min_y_q) min_y_q <= smp_y;
      if (smp_y > max_y_q) max_y_q <= smp_y;
      if (smp_z < min_z_q) min_z_q <= smp_z;
      if (smp_z > max_z_q) max_z_q <= smp_z;
    end
  end

  // Sequencer, work registers and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      sy_q          <= '0;
      sz_q          <= '0;
      yv_q          <= '0;
      zv_q          <= '0;
      axis_q        <= 1'b0;
      w_heading_q   <= '0;
      w_off_y_q     <= '0;
      w_off_z_q     <= '0;
      w_gain_y_q    <= '0;
      w_gain_z_q    <= '0;
      w_fault_q     <= 1'b0;
      w_kind_q      <= chc_pkg::RESULT_HEADING;
      out_heading_q <= '0;
      out_off_y_q   <= '0;
      out_off_z_q   <= '0;
      out_gain_y_q  <= '0;
      out_gain_z_q  <= '0;
      out_fault_q   <= 1'b0;
      out_kind_q    <= chc_pkg::RESULT_HEADING;
    end else begin
      if (out_valid_q && out_o.ready && (state_q != S_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            sy_q <= in_i.sample_y;
            sz_q <= in_i.sample_z;
            unique case (in_cmd)
              chc_pkg::CMD_HEADING: begin
                w_kind_q    <= chc_pkg::RESULT_HEADING;
                w_heading_q <= '0;
                w_off_y_q   <= '0;
                w_off_z_q   <= '0;
                w_gain_y_q  <= '0;
                w_gain_z_q  <= '0;
                w_fault_q   <= 1'b0;
                // A failed reading reports heading zero without rotating.
                state_q     <= in_i.sample_ok ? S_MUL_Y : S_EMIT;
              end
              chc_pkg::CMD_CAL_FINISH: begin
                w_kind_q    <= chc_pkg::RESULT_FINISH;
                w_heading_q <= '0;
                w_fault_q   <= 1'b0;
                axis_q      <= 1'b0;
                state_q     <= S_FIN_SET;
              end
              chc_pkg::CMD_CAL_START,
              chc_pkg::CMD_CAL_SAMPLE: state_q <= S_IDLE;
            endcase
          end
        end
        S_MUL_Y: begin
          yv_q    <= mul_p;
          state_q <= S_MUL_Z;
        end
        S_MUL_Z: begin
          zv_q    <= mul_p;
          state_q <= S_ROT;
        end
        S_ROT: begin
          state_q <= S_ROT_WAIT;
        end
        S_ROT_WAIT: begin
          if (cordic_st.done) begin
            w_heading_q <= cordic_angle;
            state_q     <= S_EMIT;
          end
        end
        S_FIN_SET: begin
          if (axis_q) w_off_z_q <= fin_half[SW-1:0];
          else        w_off_y_q <= fin_half[SW-1:0];
          if (span_bad) begin
            w_fault_q <= 1'b1;
            if (axis_q) w_gain_z_q <= GAIN_SAT;
            else        w_gain_y_q <= GAIN_SAT;
            axis_q  <= 1'b1;
            state_q <= axis_q ? S_EMIT : S_FIN_SET;
          end else begin
            state_q <= S_FIN_WAIT;
          end
        end
        S_FIN_WAIT: begin
          if (div_st.done) begin
            if (axis_q) w_gain_z_q <= div_gain;
            else        w_gain_y_q <= div_gain;
            axis_q  <= 1'b1;
            state_q <= axis_q ? S_EMIT : S_FIN_SET;
          end
        end
        S_EMIT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_heading_q <= w_heading_q;
            out_off_y_q   <= w_off_y_q;
            out_off_z_q   <= w_off_z_q;
            out_gain_y_q  <= w_gain_y_q;
            out_gain_z_q  <= w_gain_z_q;
            out_fault_q   <= w_fault_q;
            out_kind_q    <= w_kind_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.heading      = out_heading_q;
  assign out_o.new_offset_y = out_off_y_q;
  assign out_o.new_offset_z = out_off_z_q;
  assign out_o.new_gain_y   = out_gain_y_q;
  assign out_o.new_gain_z   = out_gain_z_q;
  assign out_o.calib_fault  = out_fault_q;
  assign out_o.result_kind  = out_kind_q;

  a_cordic_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_start |-> !cordic_st.busy)
    else $error("CORDIC restarted while busy");

  a_div_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_st.done |-> (state_q == S_FIN_WAIT))
    else $error("divider finished outside its wait state");

  a_finish_no_heading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == chc_pkg::RESULT_FINISH) |-> (out_o.heading == '0))
    else $error("finish result carries a heading");

  a_heading_no_cal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.result_kind == chc_pkg::RESULT_HEADING) |->
      (!out_o.calib_fault && out_o.new_gain_y == '0 && out_o.new_gain_z == '0))
    else $error("heading result carries calibration fields");

endmodule

@@ tb/compass_heading_calibration_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the compass heading and hard-iron calibration block.
module compass_heading_calibration_top_tb;
  import chc_pkg::*;

  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_ITEMS   = 300;

  localparam logic [SAMPLE_W-1:0] S_MIN = 13'h1000;
  localparam logic [SAMPLE_W-1:0] S_MAX = 13'h0FFF;

  localparam longint GAIN_ONE = longint'(1) << GAIN_FRAC_BITS_DEF;
  localparam longint GAIN_CAP = (longint'(1) << GAIN_W) - 1;
  localparam logic [GAIN_W-1:0] GAIN_SAT = GAIN_W'((GAIN_ONE > GAIN_CAP) ? GAIN_CAP : GAIN_ONE);

  // atan(2^-i) at 2^32 units per turn, entry 0 in the low word.
  localparam logic [32*ATAN_LEN-1:0] ATAN_LUT = {
    32'h0000_0051, 32'h0000_00A3, 32'h0000_0146, 32'h0000_028C,
    32'h0000_0518, 32'h0000_0A30, 32'h0000_145F, 32'h0000_28BE,
    32'h0000_517D, 32'h0000_A2FA, 32'h0001_45F3, 32'h0002_8BE6,
    32'h0005_17CC, 32'h000A_2F98, 32'h0014_5F2F, 32'h0028_BE53,
    32'h0051_7C55, 32'h00A2_F61E, 32'h0145_D7E1, 32'h028B_0D43,
    32'h0511_11D4, 32'h09FB_385B, 32'h12E4_051E, 32'h2000_0000
  };

  typedef struct packed {
    logic [HEAD_W-1:0]   heading;
    logic [SAMPLE_W-1:0] off_y;
    logic [SAMPLE_W-1:0] off_z;
    logic [GAIN_W-1:0]   gain_y;
    logic [GAIN_W-1:0]   gain_z;
    logic                fault;
    logic                kind;
  } compass_result_t;

  typedef struct packed {
    cmd_e                cmd;
    logic [SAMPLE_W-1:0] y;
    logic [SAMPLE_W-1:0] z;
    logic                ok;
    logic                typed;
    compass_result_t     res;
  } cmd_row_t;

  localparam compass_result_t HEADING_ZERO =
    '{16'd0, 13'd0, 13'd0, 25'd0, 25'd0, 1'b0, RESULT_HEADING};
  localparam compass_result_t EMPTY_FINISH =
    '{16'd0, 13'd0, 13'd0, GAIN_SAT, GAIN_SAT, 1'b1, RESULT_FINISH};

  logic clk;
  logic rst_n;

  chc_in_if  cmd_if ();
  chc_out_if res_if ();
  chc_cfg_if cfg_if ();

  compass_heading_calibration_top uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // Predictor copy of the registers and the min/max tracking.
  logic signed [SAMPLE_W-1:0] cur_off_y, cur_off_z;
  logic [GAIN_W-1:0]          cur_gain_y, cur_gain_z;
  logic signed [MM_W-1:0]     trk_min_y, trk_max_y, trk_min_z, trk_max_z;

  compass_result_t pending_results[$];
  int mismatches = 0;
  int send_calm  = 0;
  int recv_calm  = 0;

  cmd_row_t opening [25];

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_500_000;
    $display("compass_heading_calibration_top: mismatch");
    $finish;
  end

  // Mostly random waits, with an occasional stretch of back-to-back beats.
  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0) calm = $urandom_range(10, 40);
    return $urandom_range(0, 10);
  endfunction

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] v;
    case ($urandom_range(0, 3))
      0: v = SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 3))
          0:       v = S_MIN;
          1:       v = S_MAX;
          2:       v = 13'd0;
          default: v = 13'h1FFF;
        endcase
      end
      default: v = SAMPLE_W'($urandom_range(0, 64) - 32);
    endcase
    return v;
  endfunction

  function automatic logic [HEAD_W-1:0] cordic_heading(input longint yv, input longint xv);
    logic [31:0] ang;
    longint      dx, dy;
    if (yv == 0 && xv == 0) return 16'd0;
    ang = 32'd0;
    if (xv < 0) begin
      xv  = -xv;
      yv  = -yv;
      ang = 32'h8000_0000;
    end
    for (int i = 0; i < CORDIC_STEPS_DEF && i < ATAN_LEN; i++) begin
      dx = yv >>> i;
      dy = xv >>> i;
      if (yv > 0) begin
        xv  += dx;
        yv  -= dy;
        ang += ATAN_LUT[i*32 +: 32];
      end else begin
        xv  -= dx;
        yv  += dy;
        ang -= ATAN_LUT[i*32 +: 32];
      end
    end
    // Round to 16 bits; an angle just below a full turn wraps to zero.
    ang += 32'h0000_8000;
    return ang[31:16];
  endfunction

  function automatic void axis_calibration(input logic signed [MM_W-1:0] mn,
                                           input logic signed [MM_W-1:0] mx,
                                           output logic [SAMPLE_W-1:0] off_o,
                                           output logic [GAIN_W-1:0] gain_o,
                                           inout logic fault);
    int     off, span;
    longint g;
    off   = (int'(mn) + int'(mx)) / 2;
    span  = int'(mx) - off;
    off_o = off[SAMPLE_W-1:0];
    if (span <= 0) begin
      gain_o = GAIN_SAT;
      fault  = 1'b1;
    end else begin
      g      = (GAIN_ONE + longint'(span / 2)) / longint'(span);
      gain_o = GAIN_W'((g > GAIN_CAP) ? GAIN_CAP : g);
    end
  endfunction

  function automatic bit compass_predict(input cmd_e c, input logic [SAMPLE_W-1:0] y_raw,
                                         input logic [SAMPLE_W-1:0] z_raw, input logic ok,
                                         output compass_result_t r);
    longint                     yv, zv;
    logic signed [SAMPLE_W-1:0] sy, sz;
    logic                       fault;
    bit                         emits;
    r     = '0;
    sy    = y_raw;
    sz    = z_raw;
    emits = 1'b0;
    case (c)
      CMD_CAL_START: begin
        trk_min_y = MIN_RST;
        trk_min_z = MIN_RST;
        trk_max_y = MAX_RST;
        trk_max_z = MAX_RST;
      end
      CMD_CAL_SAMPLE: begin
        if (ok) begin
          if (sy < trk_min_y) trk_min_y = sy;
          if (sy > trk_max_y) trk_max_y = sy;
          if (sz < trk_min_z) trk_min_z = sz;
          if (sz > trk_max_z) trk_max_z = sz;
        end
      end
      CMD_HEADING: begin
        emits  = 1'b1;
        r.kind = RESULT_HEADING;
        if (ok) begin
          yv = (longint'(sy) - longint'(cur_off_y)) * longint'(cur_gain_y);
          zv = (longint'(sz) - longint'(cur_off_z)) * longint'(cur_gain_z);
          // The x axis of the rotation is the negated scaled z.
          r.heading = cordic_heading(yv, -zv);
        end
      end
      default: begin
        emits  = 1'b1;
        r.kind = RESULT_FINISH;
        fault  = 1'b0;
        axis_calibration(trk_min_y, trk_max_y, r.off_y, r.gain_y, fault);
        axis_calibration(trk_min_z, trk_max_z, r.off_z, r.gain_z, fault);
        r.fault = fault;
      end
    endcase
    return emits;
  endfunction

  task automatic send_command(input cmd_row_t row);
    compass_result_t r;
    int              gap;
    gap = draw_gap(send_calm);
    @(negedge clk);
    for (int k = 0; k < gap; k++) begin
      cmd_if.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= row.cmd;
    cmd_if.sample_y  <= row.y;
    cmd_if.sample_z  <= row.z;
    cmd_if.sample_ok <= row.ok;
    do @(posedge clk); while (cmd_if.ready !== 1'b1);
    if (compass_predict(row.cmd, row.y, row.z, row.ok, r))
      pending_results.push_back(row.typed ? row.res : r);
  endtask

  task automatic wait_quiet(input int settle);
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input reg_e idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    case (idx)
      REG_OFFSET_Y: cur_off_y = value[SAMPLE_W-1:0];
      REG_OFFSET_Z: cur_off_z = value[SAMPLE_W-1:0];
      REG_GAIN_Y:   cur_gain_y = value[GAIN_W-1:0];
      default:      cur_gain_z = value[GAIN_W-1:0];
    endcase
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_config(input logic [CFG_W-1:0] oy, input logic [CFG_W-1:0] oz,
                            input logic [CFG_W-1:0] gy, input logic [CFG_W-1:0] gz);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_GAIN_Y, gy);
    write_reg(REG_GAIN_Z, gz);
  endtask

  // Mostly headings and complete calibration runs, with some random commands mixed in.
  task automatic run_random(input int n);
    cmd_row_t row;
    int       count, run_len;
    count = 0;
    while (count < n) begin
      if ($urandom_range(0, 99) == 0) wait_quiet(0);
      row = '0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          row.cmd = CMD_HEADING;
          row.y   = rand_sample();
          row.z   = rand_sample();
          row.ok  = ($urandom_range(0, 9) != 0);
          send_command(row);
          count++;
        end
        5, 6, 7: begin
          row.cmd = CMD_CAL_START;
          row.y   = SAMPLE_W'($urandom);
          row.z   = SAMPLE_W'($urandom);
          row.ok  = 1'($urandom);
          send_command(row);
          run_len = $urandom_range(0, 12);
          for (int k = 0; k < run_len; k++) begin
            row.cmd = CMD_CAL_SAMPLE;
            row.y   = rand_sample();
            row.z   = rand_sample();
            row.ok  = ($urandom_range(0, 6) != 0);
            send_command(row);
          end
          row.cmd = CMD_CAL_FINISH;
          row.y   = SAMPLE_W'($urandom);
          row.z   = SAMPLE_W'($urandom);
          row.ok  = 1'($urandom);
          send_command(row);
          count += run_len + 2;
        end
        default: begin
          row.cmd = cmd_e'($urandom_range(0, 3));
          row.y   = SAMPLE_W'($urandom);
          row.z   = SAMPLE_W'($urandom);
          row.ok  = 1'($urandom);
          send_command(row);
          count++;
        end
      endcase
    end
  endtask

  task automatic check_field(input string name, input logic signed [63:0] want,
                             input logic signed [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    compass_result_t want;
    int              stall;
    res_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      stall = draw_gap(recv_calm);
      for (int k = 0; k < stall; k++) begin
        res_if.ready <= 1'b0;
        @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      if (pending_results.size() == 0) begin
        $display("%0t ns: result beat with none expected, heading %0d kind %0d",
                 $time, res_if.heading, res_if.result_kind);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("heading", want.heading, res_if.heading);
        check_field("new_offset_y", $signed(want.off_y), res_if.new_offset_y);
        check_field("new_offset_z", $signed(want.off_z), res_if.new_offset_z);
        check_field("new_gain_y", want.gain_y, res_if.new_gain_y);
        check_field("new_gain_z", want.gain_z, res_if.new_gain_z);
        check_field("calib_fault", want.fault, res_if.calib_fault);
        check_field("result_kind", want.kind, res_if.result_kind);
      end
    end
  end

  initial begin : stimulus
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_HEADING;
    cmd_if.sample_y  = '0;
    cmd_if.sample_z  = '0;
    cmd_if.sample_ok = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = REG_OFFSET_Y;
    cfg_if.data      = '0;
    rst_n            = 1'b0;

    cur_off_y  = OFFSET_Y_RST;
    cur_off_z  = OFFSET_Z_RST;
    cur_gain_y = GAIN_Y_RST;
    cur_gain_z = GAIN_Z_RST;
    trk_min_y  = MIN_RST;
    trk_min_z  = MIN_RST;
    trk_max_y  = MAX_RST;
    trk_max_z  = MAX_RST;

    // A failed read gives heading zero whatever the sample fields hold.
    opening[0]  = '{CMD_HEADING, S_MAX, S_MIN, 1'b0, 1'b1, HEADING_ZERO};
    // Nothing tracked since reset: zero offsets and a saturated, faulted gain on both axes.
    opening[1]  = '{CMD_CAL_FINISH, 13'd0, 13'd0, 1'b1, 1'b1, EMPTY_FINISH};
    // Raw readings equal to the reset offsets give the zero vector.
    opening[2]  = '{CMD_HEADING, 13'd10, -13'sd32, 1'b1, 1'b1, HEADING_ZERO};
    opening[3]  = '{CMD_HEADING, S_MAX, S_MAX, 1'b1, 1'b0, '0};
    opening[4]  = '{CMD_HEADING, S_MIN, S_MIN, 1'b1, 1'b0, '0};
    opening[5]  = '{CMD_HEADING, S_MIN, S_MAX, 1'b1, 1'b0, '0};
    opening[6]  = '{CMD_HEADING, S_MAX, S_MIN, 1'b1, 1'b0, '0};
    opening[7]  = '{CMD_HEADING, 13'd10, 13'd0, 1'b1, 1'b0, '0};
    // Exactly on the positive x axis, where the rotation ends just below zero.
    opening[8]  = '{CMD_HEADING, 13'd10, S_MIN, 1'b1, 1'b0, '0};
    opening[9]  = '{CMD_HEADING, S_MAX, -13'sd32, 1'b1, 1'b0, '0};
    opening[10] = '{CMD_HEADING, 13'h1555, 13'h0AAA, 1'b1, 1'b0, '0};
    opening[11] = '{CMD_HEADING, 13'h0AAA, 13'h1555, 1'b1, 1'b0, '0};
    opening[12] = '{CMD_CAL_START, S_MAX, S_MIN, 1'b0, 1'b0, '0};
    opening[13] = '{CMD_CAL_SAMPLE, 13'd100, -13'sd50, 1'b1, 1'b0, '0};
    opening[14] = '{CMD_CAL_SAMPLE, S_MAX, S_MIN, 1'b0, 1'b0, '0};
    // One sample only: the offset is that sample and both spans are flat.
    opening[15] = '{CMD_CAL_FINISH, S_MIN, S_MAX, 1'b1, 1'b1,
                    '{16'd0, 13'd100, -13'sd50, GAIN_SAT, GAIN_SAT, 1'b1, RESULT_FINISH}};
    opening[16] = '{CMD_CAL_SAMPLE, S_MIN, S_MAX, 1'b1, 1'b0, '0};
    opening[17] = '{CMD_CAL_SAMPLE, S_MAX, S_MIN, 1'b1, 1'b0, '0};
    opening[18] = '{CMD_CAL_FINISH, 13'd0, 13'd0, 1'b0, 1'b0, '0};
    opening[19] = '{CMD_CAL_START, 13'd0, 13'd0, 1'b1, 1'b0, '0};
    opening[20] = '{CMD_CAL_FINISH, 13'd0, 13'd0, 1'b1, 1'b1, EMPTY_FINISH};
    opening[21] = '{CMD_CAL_SAMPLE, -13'sd3, 13'd1, 1'b1, 1'b0, '0};
    opening[22] = '{CMD_CAL_SAMPLE, -13'sd6, 13'd2, 1'b1, 1'b0, '0};
    opening[23] = '{CMD_CAL_FINISH, 13'd0, 13'd0, 1'b1, 1'b0, '0};
    opening[24] = '{CMD_HEADING, 13'd0, 13'd0, 1'b0, 1'b1, HEADING_ZERO};

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (opening[i]) send_command(opening[i]);
    run_random(PHASE_ITEMS);

    for (int phase = 1; phase <= 5; phase++) begin
      wait_quiet(SETTLE_CYCLES);
      case (phase)
        1: set_config({12'hFFF, S_MIN}, {12'h000, S_MAX}, 25'd0, GAIN_SAT);
        2: set_config({12'h000, S_MAX}, {12'hFFF, S_MIN}, GAIN_SAT, 25'd0);
        3: set_config(25'd0, 25'd0, GAIN_SAT, GAIN_SAT);
        default: set_config(CFG_W'($urandom), CFG_W'($urandom),
                            CFG_W'($urandom_range(0, 1 << 24)),
                            CFG_W'($urandom_range(0, 1 << 24)));
      endcase
      run_random(PHASE_ITEMS);
    end

    wait_quiet(SETTLE_CYCLES);
    if (mismatches == 0) begin
      $display("compass_heading_calibration_top: match");
    end else begin
      $display("compass_heading_calibration_top: mismatch");
    end
    $finish;
  end

endmodule
